// ===== hw/rtl/lidar_polar_to_cartesian_assert.svh =====
// Assertion macros shared by the lidar point converter checker.
// Plain text macros only; no dependencies.
`ifndef LIDAR_POLAR_TO_CARTESIAN_ASSERT_SVH
`define LIDAR_POLAR_TO_CARTESIAN_ASSERT_SVH
// Assert an implication on every rising clock edge outside reset.
`define LPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpc assertion failed");
// Assert an implication whose consequent is checked in the next cycle.
`define LPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpc assertion failed");
`endif

// ===== hw/rtl/lpc_pkg.sv =====
// Package for the lidar point converter: widths, register indexes,
// CORDIC constants and the stage payload types. No dependencies.
package lpc_pkg;
    localparam int NumLinesDef   = 64;
    localparam int NumColumnsDef = 4096;
    localparam int CordicSteps   = 22;
    localparam logic signed [31:0] CordicGainInv = 32'sd652032874;

    typedef enum logic [2:0] {
        REG_MIN_RANGE   = 3'd0,
        REG_MAX_RANGE   = 3'd1,
        REG_YAW_START   = 3'd2,
        REG_YAW_STEP    = 3'd3,
        REG_PITCH_START = 3'd4,
        REG_PITCH_STEP  = 3'd5,
        REG_LINE_ENABLE = 3'd6
    } reg_idx_t;

    // Rotation angle per CORDIC step, 2^24 units per turn.
    function automatic logic signed [24:0] atan_unit(input int i);
        logic signed [24:0] t;
        begin
            case (i)
                0: t = 25'sd2097152;  1: t = 25'sd1238021;  2: t = 25'sd654136;
                3: t = 25'sd332050;   4: t = 25'sd166669;   5: t = 25'sd83416;
                6: t = 25'sd41718;    7: t = 25'sd20860;    8: t = 25'sd10430;
                9: t = 25'sd5215;     10: t = 25'sd2608;    11: t = 25'sd1304;
                12: t = 25'sd652;     13: t = 25'sd326;     14: t = 25'sd163;
                15: t = 25'sd81;      16: t = 25'sd41;      17: t = 25'sd20;
                18: t = 25'sd10;      19: t = 25'sd5;       20: t = 25'sd3;
                21: t = 25'sd1;
                default: t = 25'sd0;
            endcase
            atan_unit = t;
        end
    endfunction

    // One CORDIC lane: cos/sin pair in Q30 plus residual angle and fold flag.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [24:0] z;
        logic               flip;
    } cordic_lane_t;

    // Payload riding beside the rotation lanes.
    typedef struct packed {
        logic [19:0] range;
        logic [15:0] intensity;
    } side_t;

    // Round a Q30 product to nearest, ties away from zero.
    function automatic logic signed [63:0] round_q30(input logic signed [63:0] p);
        logic [63:0] mag;
        begin
            mag = p[63] ? 64'(-p) : 64'(p);
            mag = (mag + 64'd536870912) >> 30;
            round_q30 = p[63] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic [20:0] sat21(input logic signed [63:0] v);
        begin
            if (v > 64'sd1048575)
                sat21 = 21'h0FFFFF;
            else if (v < -64'sd1048576)
                sat21 = 21'h100000;
            else
                sat21 = v[20:0];
        end
    endfunction
endpackage

// ===== hw/rtl/lpc_cordic_step.sv =====
// One registered CORDIC micro-rotation stage for the yaw and pitch lanes.
// Depends on lpc_pkg.
module lpc_cordic_step #(
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  lpc_pkg::cordic_lane_t yaw_in,
    input  lpc_pkg::cordic_lane_t pit_in,
    input  lpc_pkg::side_t        side_in,
    output logic                  out_valid,
    output lpc_pkg::cordic_lane_t yaw_out,
    output lpc_pkg::cordic_lane_t pit_out,
    output lpc_pkg::side_t        side_out
);
    logic                  valid_reg;
    lpc_pkg::cordic_lane_t yaw_reg, pit_reg, yaw_next, pit_next;
    lpc_pkg::side_t        side_reg;

    function automatic lpc_pkg::cordic_lane_t rot(input lpc_pkg::cordic_lane_t a);
        lpc_pkg::cordic_lane_t r;
        logic signed [32:0] dx, dy;
        begin
            dx = a.y >>> STEP;
            dy = a.x >>> STEP;
            r = a;
            if (!a.z[24])
            begin
                r.x = a.x - dx;
                r.y = a.y + dy;
                r.z = a.z - lpc_pkg::atan_unit(STEP);
            end
            else
            begin
                r.x = a.x + dx;
                r.y = a.y - dy;
                r.z = a.z + lpc_pkg::atan_unit(STEP);
            end
            rot = r;
        end
    endfunction

    // Rotate both lanes by this step's angle.
    always_comb
    begin
        yaw_next = rot(yaw_in);
        pit_next = rot(pit_in);
    end

    // Advance valid with the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // Hold payload while stalled.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw_reg  <= yaw_next;
            pit_reg  <= pit_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign yaw_out   = yaw_reg;
    assign pit_out   = pit_reg;
    assign side_out  = side_reg;
endmodule

// ===== hw/rtl/lpc_front.sv =====
// Front end: register file, gating, angle forming and folding into CORDIC lanes.
// Depends on lpc_pkg.
module lpc_front #(
    parameter int NUM_LINES   = lpc_pkg::NumLinesDef,
    parameter int NUM_COLUMNS = lpc_pkg::NumColumnsDef
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [19:0]           range,
    input  logic [15:0]           intensity,
    input  logic [11:0]           column,
    input  logic [5:0]            line,
    output logic                  out_valid,
    output lpc_pkg::cordic_lane_t yaw_out,
    output lpc_pkg::cordic_lane_t pit_out,
    output lpc_pkg::side_t        side_out
);
    logic [19:0] min_range_reg, max_range_reg;
    logic [15:0] yaw_start_reg, yaw_step_reg, pitch_start_reg, pitch_step_reg;
    logic [63:0] line_enable_reg;
    // stage A: gated angles
    logic        a_valid_reg;
    logic [15:0] a_yaw_reg, a_pit_reg;
    lpc_pkg::side_t a_side_reg;
    logic        keep;
    logic [15:0] yaw_next, pit_next;
    // stage B: folded lanes
    logic        b_valid_reg;
    lpc_pkg::cordic_lane_t b_yaw_reg, b_pit_reg;
    lpc_pkg::side_t b_side_reg;

    // Write configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg   <= 20'd0;
            max_range_reg   <= 20'hFFFFF;
            yaw_start_reg   <= 16'h8000;
            yaw_step_reg    <= 16'd16;
            pitch_start_reg <= 16'(65536 - 2730);
            pitch_step_reg  <= 16'd86;
            line_enable_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpc_pkg::REG_MIN_RANGE:   min_range_reg   <= cfg_data[19:0];
                lpc_pkg::REG_MAX_RANGE:   max_range_reg   <= cfg_data[19:0];
                lpc_pkg::REG_YAW_START:   yaw_start_reg   <= cfg_data[15:0];
                lpc_pkg::REG_YAW_STEP:    yaw_step_reg    <= cfg_data[15:0];
                lpc_pkg::REG_PITCH_START: pitch_start_reg <= cfg_data[15:0];
                lpc_pkg::REG_PITCH_STEP:  pitch_step_reg  <= cfg_data[15:0];
                lpc_pkg::REG_LINE_ENABLE: line_enable_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Gate the return and form wrapping angles.
    always_comb
    begin
        keep = (32'(line) < 32'(NUM_LINES)) && (32'(column) < 32'(NUM_COLUMNS))
            && line_enable_reg[line] && (min_range_reg < range)
            && (range < max_range_reg);
        yaw_next = 16'(32'(column) * 32'(yaw_step_reg)) + yaw_start_reg;
        pit_next = 16'(32'(line) * 32'(pitch_step_reg)) + pitch_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid && keep;
            b_valid_reg <= a_valid_reg;
        end
    end

    function automatic lpc_pkg::cordic_lane_t fold(input logic [15:0] ang);
        lpc_pkg::cordic_lane_t l;
        logic [15:0] a;
        logic        fl;
        begin
            fl = (16'(ang + 16'd16384) >= 16'd32768);
            a  = fl ? 16'(ang + 16'd32768) : ang;
            l.x = 33'(lpc_pkg::CordicGainInv);
            l.y = '0;
            l.z = {{1{a[15]}}, a, 8'd0};
            l.flip = fl;
            fold = l;
        end
    endfunction

    // Hold payload while stalled.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_yaw_reg  <= yaw_next;
            a_pit_reg  <= pit_next;
            a_side_reg <= '{range: range, intensity: intensity};
            b_yaw_reg  <= fold(a_yaw_reg);
            b_pit_reg  <= fold(a_pit_reg);
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign yaw_out   = b_yaw_reg;
    assign pit_out   = b_pit_reg;
    assign side_out  = b_side_reg;
endmodule

// ===== hw/rtl/lpc_back.sv =====
// Back end: Q30 products, rounding, saturation and output register.
// Depends on lpc_pkg.
module lpc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  lpc_pkg::cordic_lane_t yaw_in,
    input  lpc_pkg::cordic_lane_t pit_in,
    input  lpc_pkg::side_t        side_in,
    output logic                  out_valid,
    output logic [20:0]           x_pos,
    output logic [20:0]           y_pos,
    output logic [20:0]           z_pos,
    output logic [15:0]           point_intensity
);
    // stage 1: signed sin/cos, h product, z product
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [32:0] s1_cy_reg, s1_sy_reg;
    logic signed [63:0] s1_hp_reg, s1_zp_reg;
    logic [15:0]        s1_int_reg, s2_int_reg, s3_int_reg;
    // stage 2: rounded h, xy products, rounded z
    logic signed [63:0] s2_xp_reg, s2_yp_reg, s2_zp_reg;
    logic signed [21:0] h_next;
    logic signed [32:0] cp, sp;
    logic [20:0]        s3_x_reg, s3_y_reg, s3_z_reg;

    always_comb
    begin
        cp = pit_in.flip ? -pit_in.x : pit_in.x;
        sp = pit_in.flip ? -pit_in.y : pit_in.y;
        // h stays within the range magnitude, so 22 signed bits hold it
        h_next = 22'(lpc_pkg::round_q30(s1_hp_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Hold payload while stalled.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cy_reg  <= yaw_in.flip ? -yaw_in.x : yaw_in.x;
            s1_sy_reg  <= yaw_in.flip ? -yaw_in.y : yaw_in.y;
            s1_hp_reg  <= $signed({1'b0, side_in.range}) * cp;
            s1_zp_reg  <= $signed({1'b0, side_in.range}) * sp;
            s1_int_reg <= side_in.intensity;
            s2_xp_reg  <= h_next * s1_cy_reg;
            s2_yp_reg  <= h_next * s1_sy_reg;
            s2_zp_reg  <= lpc_pkg::round_q30(s1_zp_reg);
            s2_int_reg <= s1_int_reg;
            s3_x_reg   <= lpc_pkg::sat21(lpc_pkg::round_q30(s2_xp_reg));
            s3_y_reg   <= lpc_pkg::sat21(lpc_pkg::round_q30(s2_yp_reg));
            s3_z_reg   <= lpc_pkg::sat21(s2_zp_reg);
            s3_int_reg <= s2_int_reg;
        end
    end

    assign out_valid       = s3_valid_reg;
    assign x_pos           = s3_x_reg;
    assign y_pos           = s3_y_reg;
    assign z_pos           = s3_z_reg;
    assign point_intensity = s3_int_reg;
endmodule

// ===== hw/rtl/lidar_polar_to_cartesian.sv =====
// 27 register stages (2 front, 22 CORDIC, 3 multiply/round). Throughput one
// return per cycle while the output is not stalled.
// The whole pipeline advances when the output stage is empty or taken, so a
// stall freezes every stage. Asynchronous active-low reset empties the
// pipeline and loads register defaults. Dropped returns leave a bubble.
module lidar_polar_to_cartesian #(
    parameter int NUM_LINES   = lpc_pkg::NumLinesDef,
    parameter int NUM_COLUMNS = lpc_pkg::NumColumnsDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // range[19:0], intensity[35:20], column[47:36], line[53:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // x_pos[20:0], y_pos[41:21], z_pos[62:42], intensity[78:63]
);
    localparam int Steps = lpc_pkg::CordicSteps;
    logic adv;
    logic                  v [Steps+1];
    lpc_pkg::cordic_lane_t yl [Steps+1];
    lpc_pkg::cordic_lane_t pl [Steps+1];
    lpc_pkg::side_t        sd [Steps+1];
    logic [20:0] xo, yo, zo;
    logic [15:0] io;

    // Advance when the output register is free or being taken.
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    lpc_front #(.NUM_LINES(NUM_LINES), .NUM_COLUMNS(NUM_COLUMNS)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .adv(adv), .in_valid(s_axis_tvalid),
        .range(s_axis_tdata[19:0]), .intensity(s_axis_tdata[35:20]),
        .column(s_axis_tdata[47:36]), .line(s_axis_tdata[53:48]),
        .out_valid(v[0]), .yaw_out(yl[0]), .pit_out(pl[0]), .side_out(sd[0])
    );

    for (genvar g = 0; g < Steps; g++)
    begin : g_cordic
        lpc_cordic_step #(.STEP(g)) u_step (
            .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v[g]),
            .yaw_in(yl[g]), .pit_in(pl[g]), .side_in(sd[g]),
            .out_valid(v[g+1]), .yaw_out(yl[g+1]), .pit_out(pl[g+1]),
            .side_out(sd[g+1])
        );
    end

    lpc_back u_back (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v[Steps]),
        .yaw_in(yl[Steps]), .pit_in(pl[Steps]), .side_in(sd[Steps]),
        .out_valid(m_axis_tvalid), .x_pos(xo), .y_pos(yo), .z_pos(zo),
        .point_intensity(io)
    );

    assign m_axis_tdata = {1'b0, io, zo, yo, xo};
endmodule

// ===== hw/rtl/lpc_checker.sv =====
// Port-level checker for the lidar point converter, bound to the top level.
// Depends on lidar_polar_to_cartesian_assert.svh.
`include "lidar_polar_to_cartesian_assert.svh"
module lpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    `LPC_ASSERT_IMPL(a_ready_free, !m_axis_tvalid, s_axis_tready)
    `LPC_ASSERT_IMPL(a_ready_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `LPC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `LPC_ASSERT_IMPL(a_pad, m_axis_tvalid, m_axis_tdata[79] == 1'b0)
endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
